// File: hdl/kpzeu_pkg.sv
// Shared types and constants for the KPZ node Euler update unit.
// Used by the front, queue, back and top-level files; depends on nothing.
package kpzeu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;
  localparam int CNT_W = 4;
  localparam int NSUM_W = 40;
  localparam int SQ_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NONLINEAR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_COEF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_COEF = 3'd4;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [3:0] EXP_LAST = 4'd12;

  typedef struct packed {
    logic signed [31:0]       center;
    logic signed [15:0]       noise;
    logic signed [NSUM_W-1:0] nsum;
    logic [CNT_W-1:0]         cnt;
    logic [SQ_W-1:0]          sq;
    logic                     dropped;
  } job_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } fifo_stat_t;

  // floor(2^32 / k) for the series divide
  function automatic logic [32:0] recip(input logic [3:0] k);
    logic [32:0] r;
    case (k)
      4'd1:    r = 33'h1_0000_0000;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/kpz_graph_node_euler_update_unit.sv
// Top level of the KPZ node Euler update unit: config registers, front, queue, back.
// Depends on kpzeu_pkg, kpzeu_front, kpzeu_fifo and kpzeu_back.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_push / in_full  | first, last, centre, noise, neighbor
//  out_    | output    | out_pop / out_empty| new_height, saturated
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// The front takes one neighbor item per cycle while in_full is low and moves each
// node through stages a and b to the job queue after its last item. The back sums
// the Taylor series twice and multiplies by exp(-1) once per unit of n, the integer
// part of c*G (up to 31), skipping both when c*G reaches 32. A four-entry job queue
// parts the two; in_full counts in-flight nodes too. Reset is synchronous, active low.
module kpz_graph_node_euler_update_unit #(
  parameter int MAX_NEIGHBORS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic                                   in_first_neighbor,
  input  logic                                   in_last_neighbor,
  input  logic signed [31:0]                     in_center_height,
  input  logic signed [15:0]                     in_noise_sample,
  input  logic signed [31:0]                     in_neighbor_height,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [31:0]                     out_new_height,
  output logic                                   out_saturated,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [kpzeu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kpzeu_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import kpzeu_pkg::*;

  logic [15:0]        diffusion_gain_r, noise_gain_r;
  logic signed [23:0] nonlinear_gain_r;
  logic [23:0]        saturation_coef_r, inverse_coef_r;
  logic               job_push, job_pop, out_valid;
  job_t               job_w, job_r;
  fifo_stat_t         fifo_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diffusion_gain_r <= '0;
      nonlinear_gain_r <= '0;
      noise_gain_r <= '0;
      saturation_coef_r <= 24'h01_0000;
      inverse_coef_r <= 24'h01_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIFFUSION: diffusion_gain_r <= cfg_data[15:0];
        CFG_NONLINEAR: nonlinear_gain_r <= cfg_data;
        CFG_NOISE:     noise_gain_r <= cfg_data[15:0];
        CFG_SAT_COEF:  saturation_coef_r <= cfg_data;
        CFG_INV_COEF:  inverse_coef_r <= cfg_data;
        default: ;
      endcase
    end
  end

  kpzeu_front #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_first_neighbor  (in_first_neighbor),
    .in_last_neighbor   (in_last_neighbor),
    .in_center_height   (in_center_height),
    .in_noise_sample    (in_noise_sample),
    .in_neighbor_height (in_neighbor_height),
    .fifo_stat          (fifo_stat),
    .job_push           (job_push),
    .job                (job_w)
  );

  kpzeu_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_w),
    .pop   (job_pop),
    .rdata (job_r),
    .stat  (fifo_stat)
  );

  kpzeu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_in          (job_r),
    .job_empty       (fifo_stat.empty),
    .job_pop         (job_pop),
    .diffusion_gain  (diffusion_gain_r),
    .nonlinear_gain  (nonlinear_gain_r),
    .noise_gain      (noise_gain_r),
    .saturation_coef (saturation_coef_r),
    .inverse_coef    (inverse_coef_r),
    .out_valid       (out_valid),
    .out_pop         (out_pop),
    .out_new_height  (out_new_height),
    .out_saturated   (out_saturated)
  );

  assign out_empty = ~out_valid;

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !fifo_stat.full)
    else $error("job queue written while full");

  a_no_queue_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !fifo_stat.empty)
    else $error("job queue read while empty");

  a_full_bounds_queue: assert property (@(posedge clk) disable iff (!rst_n)
    !in_full |-> (fifo_stat.count < QCNT_W'(QDEPTH)))
    else $error("input open with job queue full");

endmodule

// File: hdl/kpzeu_front.sv
// Front end: takes neighbor items, squares differences and accumulates per node.
// Pushes a finished node record into the job queue. Depends on kpzeu_pkg.
module kpzeu_front #(
  parameter int MAX_NEIGHBORS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_first_neighbor,
  input  logic                  in_last_neighbor,
  input  logic signed [31:0]    in_center_height,
  input  logic signed [15:0]    in_noise_sample,
  input  logic signed [31:0]    in_neighbor_height,
  input  kpzeu_pkg::fifo_stat_t fifo_stat,
  output logic                  job_push,
  output kpzeu_pkg::job_t       job
);
  import kpzeu_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NEIGHBORS);

  logic                     accept;
  logic signed [31:0]       cen_eff;
  logic signed [15:0]       noise_eff;
  logic [CNT_W-1:0]         cnt_base, cnt_new;
  logic                     keep, drop_new;
  logic signed [32:0]       diff;
  logic [32:0]              ad;
  logic [QCNT_W:0]          pending;

  logic signed [31:0]       held_c_r, held_n_r_c;
  logic signed [15:0]       held_n_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     drop_r;

  logic                     a_v_r, a_first_r, a_last_r, a_keep_r, a_drop_r;
  logic signed [31:0]       a_nb_r, a_cen_r;
  logic signed [15:0]       a_noise_r;
  logic [32:0]              a_ad_r;
  logic [CNT_W-1:0]         a_cnt_r;

  logic                     b_v_r, b_first_r, b_last_r, b_keep_r, b_drop_r;
  logic signed [31:0]       b_nb_r, b_cen_r;
  logic signed [15:0]       b_noise_r;
  logic [48:0]              b_sq_r;
  logic [CNT_W-1:0]         b_cnt_r;
  logic [65:0]              sq_full;

  logic signed [NSUM_W-1:0] nsum_r, nsum_base, nsum_nxt;
  logic [SQ_W-1:0]          sq_r, sq_base, sq_nxt;

  assign held_n_r_c = {{16{held_n_r[15]}}, held_n_r};

  // Reserve a queue slot for every last item still in the pipe.
  assign pending = {1'b0, fifo_stat.count} + (QCNT_W+1)'(a_v_r & a_last_r)
                 + (QCNT_W+1)'(b_v_r & b_last_r);
  assign in_full = (pending >= (QCNT_W+1)'(QDEPTH));
  assign accept = in_push & ~in_full;

  always_comb begin
    cen_eff = in_first_neighbor ? in_center_height : held_c_r;
    noise_eff = in_first_neighbor ? in_noise_sample : held_n_r_c[15:0];
    cnt_base = in_first_neighbor ? '0 : cnt_r;
    keep = (cnt_base < MAX_CNT);
    cnt_new = keep ? cnt_base + 1'b1 : cnt_base;
    drop_new = (in_first_neighbor ? 1'b0 : drop_r) | ~keep;
    diff = {cen_eff[31], cen_eff} - {in_neighbor_height[31], in_neighbor_height};
    ad = diff[32] ? (33'd0 - diff) : diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_c_r <= '0;
      held_n_r <= '0;
      cnt_r <= '0;
      drop_r <= 1'b0;
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= accept;
      if (accept) begin
        if (in_first_neighbor) begin
          held_c_r <= in_center_height;
          held_n_r <= in_noise_sample;
        end
        if (in_last_neighbor) begin
          cnt_r <= '0;
          drop_r <= 1'b0;
        end else begin
          cnt_r <= cnt_new;
          drop_r <= drop_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    a_first_r <= in_first_neighbor;
    a_last_r <= in_last_neighbor;
    a_keep_r <= keep;
    a_drop_r <= drop_new;
    a_nb_r <= in_neighbor_height;
    a_cen_r <= cen_eff;
    a_noise_r <= noise_eff;
    a_ad_r <= ad;
    a_cnt_r <= cnt_new;
  end

  assign sq_full = a_ad_r * a_ad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b_first_r <= a_first_r;
    b_last_r <= a_last_r;
    b_keep_r <= a_keep_r;
    b_drop_r <= a_drop_r;
    b_nb_r <= a_nb_r;
    b_cen_r <= a_cen_r;
    b_noise_r <= a_noise_r;
    b_sq_r <= sq_full[FRAC_BITS +: 49];
    b_cnt_r <= a_cnt_r;
  end

  always_comb begin
    nsum_base = b_first_r ? '0 : nsum_r;
    sq_base = b_first_r ? '0 : sq_r;
    nsum_nxt = nsum_base + (b_keep_r ? {{(NSUM_W-32){b_nb_r[31]}}, b_nb_r} : '0);
    sq_nxt = sq_base + (b_keep_r ? {{(SQ_W-49){1'b0}}, b_sq_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nsum_r <= '0;
      sq_r <= '0;
    end else if (b_v_r) begin
      // clear the sums once a node has been handed on
      if (b_last_r) begin
        nsum_r <= '0;
        sq_r <= '0;
      end else begin
        nsum_r <= nsum_nxt;
        sq_r <= sq_nxt;
      end
    end
  end

  assign job_push = b_v_r & b_last_r;
  assign job.center = b_cen_r;
  assign job.noise = b_noise_r;
  assign job.nsum = nsum_nxt;
  assign job.cnt = b_cnt_r;
  assign job.sq = sq_nxt;
  assign job.dropped = b_drop_r;

endmodule

// File: hdl/kpzeu_fifo.sv
// Short job queue between the front and back ends of the KPZ update unit.
// Holds finished node records; depends on kpzeu_pkg.
module kpzeu_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  kpzeu_pkg::job_t       wdata,
  input  logic                  pop,
  output kpzeu_pkg::job_t       rdata,
  output kpzeu_pkg::fifo_stat_t stat
);
  import kpzeu_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full = (count_r == QCNT_W'(QDEPTH));
  assign do_push = push & ~stat.full;
  assign do_pop = pop & ~stat.empty;
  assign rdata = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: hdl/kpzeu_back.sv
// Back end: sequential Laplacian, bounded gradient (Taylor exp) and final sum.
// Owns the result register. Depends on kpzeu_pkg.
module kpzeu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  kpzeu_pkg::job_t    job_in,
  input  logic               job_empty,
  output logic               job_pop,
  input  logic [15:0]        diffusion_gain,
  input  logic signed [23:0] nonlinear_gain,
  input  logic [15:0]        noise_gain,
  input  logic [23:0]        saturation_coef,
  input  logic [23:0]        inverse_coef,
  output logic               out_valid,
  input  logic               out_pop,
  output logic signed [31:0] out_new_height,
  output logic               out_saturated
);
  import kpzeu_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P1 = 4'd1;
  localparam logic [3:0] S_P2 = 4'd2;
  localparam logic [3:0] S_XF = 4'd3;
  localparam logic [3:0] S_SMUL = 4'd4;
  localparam logic [3:0] S_SDIV = 4'd5;
  localparam logic [3:0] S_SCOR = 4'd6;
  localparam logic [3:0] S_POW = 4'd7;
  localparam logic [3:0] S_GR1 = 4'd8;
  localparam logic [3:0] S_GR2 = 4'd9;
  localparam logic [3:0] S_SUM = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]         state_r, state_nxt;
  job_t               job_r;
  logic signed [36:0] pcnt_r;
  logic [47:0]        pl_r;
  logic [40:0]        ph_r;
  logic signed [32:0] nz_r;
  logic signed [41:0] lap_r;
  logic signed [58:0] nu_r;
  logic [15:0]        f_r;
  logic [4:0]         n_r;
  logic               pass_r;
  logic [30:0]        term_r, v_r, q0_r, e_r, e1_r;
  logic signed [32:0] ssum_r;
  logic [3:0]         k_r;
  logic [54:0]        gp_r;
  logic signed [49:0] nl_r;
  logic signed [31:0] h_r;
  logic               sat_r;
  logic               ov_r;

  logic [40:0]        g;
  logic [64:0]        xsum;
  logic [48:0]        x;
  logic [16:0]        fsel;
  logic [47:0]        vprod;
  logic [63:0]        qprod;
  logic [34:0]        qk, rem;
  logic [30:0]        q, ser_res;
  logic signed [32:0] ser;
  logic [61:0]        pprod;
  logic signed [45:0] hsum;
  logic               hi_clip, lo_clip, load_out;

  always_comb begin
    g = (job_r.sq > 64'h100_0000_0000) ? 41'h100_0000_0000 : job_r.sq[40:0];
    xsum = {ph_r, 24'd0} + {17'd0, pl_r};
    x = xsum[64:16];
    fsel = pass_r ? {1'b0, f_r} : 17'h1_0000;
    vprod = term_r * fsel;
    qprod = v_r * recip(k_r);
    qk = q0_r * k_r;
    rem = {4'd0, v_r} - qk;
    // reciprocal estimate is at most one short
    q = (rem >= {31'd0, k_r}) ? q0_r + 1'b1 : q0_r;
    ser = k_r[0] ? ssum_r - $signed({2'b00, q}) : ssum_r + $signed({2'b00, q});
    ser_res = ser[32] ? 31'd0 : ser[30:0];
    pprod = e_r * e1_r;
    hsum = {{14{job_r.center[31]}}, job_r.center}
         + {{3{nu_r[58]}}, nu_r[58:16]}
         + {{12{nl_r[49]}}, nl_r[49:16]}
         + {{25{nz_r[32]}}, nz_r[32:12]};
    hi_clip = ~hsum[45] & (|hsum[44:31]);
    lo_clip = hsum[45] & ~(&hsum[44:31]);
  end

  assign job_pop = (state_r == S_IDLE) & ~job_empty;
  assign load_out = (state_r == S_DONE) & (~ov_r | out_pop);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (!job_empty) state_nxt = S_P1;
      S_P1:   state_nxt = S_P2;
      S_P2:   state_nxt = S_XF;
      S_XF:   state_nxt = (|x[48:21]) ? S_GR1 : S_SMUL;
      S_SMUL: state_nxt = S_SDIV;
      S_SDIV: state_nxt = S_SCOR;
      S_SCOR: state_nxt = (k_r == EXP_LAST && pass_r) ? S_POW : S_SMUL;
      S_POW:  if (n_r == '0) state_nxt = S_GR1;
      S_GR1:  state_nxt = S_GR2;
      S_GR2:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_DONE;
      S_DONE: if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: job_r <= job_in;
      S_P1: begin
        pcnt_r <= $signed({1'b0, job_r.cnt}) * job_r.center;
        pl_r <= g[23:0] * saturation_coef;
        nz_r <= $signed({1'b0, noise_gain}) * job_r.noise;
      end
      S_P2: begin
        lap_r <= {{2{job_r.nsum[39]}}, job_r.nsum} - {{5{pcnt_r[36]}}, pcnt_r};
        ph_r <= g[40:24] * saturation_coef;
      end
      S_XF: begin
        nu_r <= $signed({1'b0, diffusion_gain}) * lap_r;
        f_r <= x[15:0];
        n_r <= x[20:16];
        e_r <= '0;
        pass_r <= 1'b0;
        term_r <= Q30_ONE;
        ssum_r <= {2'b00, Q30_ONE};
        k_r <= 4'd1;
      end
      S_SMUL: v_r <= vprod[46:16];
      S_SDIV: q0_r <= qprod[62:32];
      S_SCOR: begin
        if (k_r == EXP_LAST) begin
          // first pass gives exp(-1), second exp(-frac)
          if (!pass_r) begin
            e1_r <= ser_res;
            pass_r <= 1'b1;
            term_r <= Q30_ONE;
            ssum_r <= {2'b00, Q30_ONE};
            k_r <= 4'd1;
          end else begin
            e_r <= ser_res;
          end
        end else begin
          term_r <= q;
          ssum_r <= ser;
          k_r <= k_r + 1'b1;
        end
      end
      S_POW: begin
        if (n_r != '0) begin
          e_r <= pprod[60:30];
          n_r <= n_r - 1'b1;
        end
      end
      S_GR1: gp_r <= (Q30_ONE - e_r) * inverse_coef;
      S_GR2: nl_r <= nonlinear_gain * $signed({1'b0, gp_r[54:30]});
      S_SUM: begin
        h_r <= hi_clip ? 32'sh7FFF_FFFF : (lo_clip ? 32'sh8000_0000 : hsum[31:0]);
        sat_r <= job_r.dropped | hi_clip | lo_clip;
      end
      default: ;
    endcase
    if (load_out) begin
      out_new_height <= h_r;
      out_saturated <= sat_r;
    end
  end

  assign out_valid = ov_r;

endmodule
